/* src/pwci_pkg.sv */
// Shared widths, types, register indexes and constants of the PID block.
package pwci_pkg;

    // Data path widths.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int DRIVE_W    = 16;

    // Widest product is gain times the error difference, which needs one extra bit.
    localparam int DIFF_W = DATA_WIDTH + 1;
    localparam int PROD_W = GAIN_W + DIFF_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } t_cfg_reg;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [DRIVE_W-1:0]    t_drive;

    // Saturation bounds of the data word and of the drive word.
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        SUM_W'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
    localparam logic signed [DATA_WIDTH:0] DRIVE_MAX = (DATA_WIDTH + 1)'(32767);
    localparam logic signed [DATA_WIDTH:0] DRIVE_MIN = -(DATA_WIDTH + 1)'(32768);

    // Added to a negative value before the shift so that it truncates toward zero.
    localparam logic signed [DATA_WIDTH:0] TRUNC_BIAS =
        (DATA_WIDTH + 1)'((65'sd1 <<< FRAC_BITS) - 65'sd1);

endpackage

/* src/pwci_if.sv */
// Handshake channels of the PID block: error items, result items and register writes.
interface pwci_item_if import pwci_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    t_data error_in;

    modport source(output valid, action, error_in, input ready);
    modport sink(input valid, action, error_in, output ready);
endinterface

interface pwci_result_if import pwci_pkg::*; ();
    logic   valid;
    logic   ready;
    t_data  control_value;
    t_drive drive_word;

    modport source(output valid, control_value, drive_word, input ready);
    modport sink(input valid, control_value, drive_word, output ready);
endinterface

interface pwci_cfg_if import pwci_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* src/pid_with_clamped_integral.sv */
// Positional PID controller with clamped integral, output clamp and drive word.
//
// Usage: each item on i_item carries an action bit and a signed Q16.16 error.
// Action 0 runs one controller step; action 1 clears the integral and the
// previous error and returns a zero result. Every item gives exactly one
// result on o_result: the clamped Q16.16 control value and a 16-bit drive
// word (integer part truncated toward zero, clipped to int16).
// Gains and limits are written on i_cfg, which is always ready; write them
// only while no item is in flight. Indexes beyond the register list are ignored.
// Throughput is one item per cycle while the receiver takes results: a five-stage
// pipeline (input register, integral update, three parallel multipliers, term sum,
// saturation and clamp) with the integral add and clamp as the only loop.
// Each stage holds its item while the next stage is full and stalled, so a stalled
// receiver fills empty stages before i_item.ready drops.
// Reset clears all gains, limits, the integral, the previous error and every
// stage valid bit.
module pid_with_clamped_integral import pwci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pwci_item_if.sink     i_item,
    pwci_cfg_if.sink      i_cfg,
    pwci_result_if.source o_result
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LIMIT_W-1:0]       r_integral_limit, r_output_limit;

    // Controller state.
    t_data r_integral, r_prev_error;

    // Pipeline stage registers.
    logic                     r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic                     r_a_action;
    t_data                    r_a_error;
    t_data                    r_b_error, r_b_integ;
    logic signed [DIFF_W-1:0] r_b_diff;
    logic signed [PROD_W-1:0] r_prod_p, r_prod_i, r_prod_d;
    logic signed [SUM_W-1:0]  r_d_sum;
    t_data                    r_value;
    t_drive                   r_drive;

    // Stage ready chain: a stage takes a new item when it is empty or moves on.
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    assign rdy_e = !r_e_valid || o_result.ready;
    assign rdy_d = !r_d_valid || rdy_e;
    assign rdy_c = !r_c_valid || rdy_d;
    assign rdy_b = !r_b_valid || rdy_c;
    assign rdy_a = !r_a_valid || rdy_b;

    assign i_item.ready = rdy_a;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_e_valid;
    assign o_result.control_value = r_value;
    assign o_result.drive_word    = r_drive;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= '0;
            r_gain_i         <= '0;
            r_gain_d         <= '0;
            r_integral_limit <= '0;
            r_output_limit   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GAIN_P:         r_gain_p         <= i_cfg.data;
                CFG_GAIN_I:         r_gain_i         <= i_cfg.data;
                CFG_GAIN_D:         r_gain_d         <= i_cfg.data;
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg.data[LIMIT_W-1:0];
                CFG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_item.valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
            if (rdy_d) r_d_valid <= r_c_valid;
            if (rdy_e) r_e_valid <= r_d_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_action <= i_item.action;
            r_a_error  <= i_item.error_in;
        end
    end

    // Integral update: add the error, then clamp to the integral limit.
    logic signed [DIFF_W-1:0] n_integ_wide, lim_integ, n_integ_clamped, n_diff;

    always_comb begin
        n_integ_wide = {r_integral[DATA_WIDTH-1], r_integral}
                     + {r_a_error[DATA_WIDTH-1], r_a_error};
        lim_integ    = {2'b00, r_integral_limit};
        if (n_integ_wide > lim_integ) begin
            n_integ_clamped = lim_integ;
        end else if (n_integ_wide < -lim_integ) begin
            n_integ_clamped = -lim_integ;
        end else begin
            n_integ_clamped = n_integ_wide;
        end
        n_diff = {r_a_error[DATA_WIDTH-1], r_a_error}
               - {r_prev_error[DATA_WIDTH-1], r_prev_error};
    end

    // State moves with the item leaving the input register. A clear zeroes
    // every operand, so the later stages produce a zero result by themselves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_error <= '0;
        end else if (r_a_valid && rdy_b) begin
            if (r_a_action) begin
                r_integral   <= '0;
                r_prev_error <= '0;
            end else begin
                r_integral   <= n_integ_clamped[DATA_WIDTH-1:0];
                r_prev_error <= r_a_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            if (r_a_action) begin
                r_b_error <= '0;
                r_b_integ <= '0;
                r_b_diff  <= '0;
            end else begin
                r_b_error <= r_a_error;
                r_b_integ <= n_integ_clamped[DATA_WIDTH-1:0];
                r_b_diff  <= n_diff;
            end
        end
    end

    // Three independent products.
    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_prod_p <= PROD_W'(r_gain_p) * PROD_W'(r_b_error);
            r_prod_i <= PROD_W'(r_gain_i) * PROD_W'(r_b_integ);
            r_prod_d <= PROD_W'(r_gain_d) * PROD_W'(r_b_diff);
        end
    end

    // Floor-shift each product back to Q16.16 and add the terms exactly.
    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_sum <= SUM_W'(r_prod_p >>> FRAC_BITS)
                     + SUM_W'(r_prod_i >>> FRAC_BITS)
                     + SUM_W'(r_prod_d >>> FRAC_BITS);
        end
    end

    // Saturate to the data word, clamp to the output limit, derive the drive word.
    logic signed [SUM_W-1:0]      sat_sum;
    logic signed [DATA_WIDTH:0]   sat_val, lim_out, n_value_wide, drive_biased, drive_trunc;
    logic signed [DATA_WIDTH:0]   drive_clip;

    always_comb begin
        if (r_d_sum > SUM_MAX) begin
            sat_sum = SUM_MAX;
        end else if (r_d_sum < SUM_MIN) begin
            sat_sum = SUM_MIN;
        end else begin
            sat_sum = r_d_sum;
        end
        sat_val = sat_sum[DATA_WIDTH:0];
        lim_out = {2'b00, r_output_limit};
        if (sat_val > lim_out) begin
            n_value_wide = lim_out;
        end else if (sat_val < -lim_out) begin
            n_value_wide = -lim_out;
        end else begin
            n_value_wide = sat_val;
        end
        drive_biased = n_value_wide[DATA_WIDTH] ? n_value_wide + TRUNC_BIAS : n_value_wide;
        drive_trunc  = drive_biased >>> FRAC_BITS;
        if (drive_trunc > DRIVE_MAX) begin
            drive_clip = DRIVE_MAX;
        end else if (drive_trunc < DRIVE_MIN) begin
            drive_clip = DRIVE_MIN;
        end else begin
            drive_clip = drive_trunc;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_value <= n_value_wide[DATA_WIDTH-1:0];
            r_drive <= drive_clip[DRIVE_W-1:0];
        end
    end

endmodule

/* src/pwci_checker.sv */
// Port-level assertions for the PID block and the bind that attaches them.
module pwci_checker import pwci_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_data  i_control_value,
    input t_drive i_drive_word
);

    // Drive word expected from the control value: truncate toward zero.
    logic signed [DATA_WIDTH:0] exp_biased, exp_drive;

    always_comb begin
        exp_biased = {i_control_value[DATA_WIDTH-1], i_control_value};
        if (i_control_value[DATA_WIDTH-1]) begin
            exp_biased = exp_biased + TRUNC_BIAS;
        end
        exp_drive = exp_biased >>> FRAC_BITS;
    end

    // No result is offered in the cycle after a reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // With the result register empty, the whole pipeline can advance.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result waits");

    // The drive word always follows from the control value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_drive_word == exp_drive[DRIVE_W-1:0])
        else $error("drive word does not match control value");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_control_value)
            && $stable(i_drive_word))
        else $error("stalled result changed");

endmodule

bind pid_with_clamped_integral pwci_checker u_pwci_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_control_value (o_result.control_value),
    .i_drive_word    (o_result.drive_word)
);
